[sv/assert_macros.svh]
// Assertion macros for the RTL; the binning core includes them.
// Each macro expands to one labeled concurrent assertion on clk / rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every edge outside reset.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[sv/pcls_pkg.sv]
// Package for the point-to-scan binning block: payload types, item kinds,
// sequencer states, constants and the arctangent table. No dependencies.
package pcls_pkg;
  localparam int BinCount = 360;
  localparam int CoordBits = 16;
  localparam int AngBits = 20;
  localparam int CordicSteps = 20;
  localparam int GuardBits = 16;
  localparam int RangeBits = 16;

  typedef enum logic [1:0] {
    KIND_POINT = 2'd0,
    KIND_READ  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_MIN_HEIGHT = 2'd0,
    REG_MAX_HEIGHT = 2'd1,
    REG_DEFAULT    = 2'd2
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CORDIC,
    ST_SQRT,
    ST_UPDATE,
    ST_READ,
    ST_RESULT,
    ST_CLEAR
  } state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic signed [CoordBits-1:0] x_mm;
    logic signed [CoordBits-1:0] y_mm;
    logic signed [CoordBits-1:0] z_mm;
    logic        point_invalid;
    logic [8:0]  read_bin;
  } in_item_t;

  typedef struct packed {
    logic [8:0]  bin_number;
    logic [15:0] range_mm;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [15:0] data;
  } cfg_item_t;

  function automatic logic [AngBits-1:0] atan_unit(input logic [4:0] i);
    logic [AngBits-1:0] v;
    case (i)
      5'd0:  v = 20'd262144;
      5'd1:  v = 20'd154753;
      5'd2:  v = 20'd81767;
      5'd3:  v = 20'd41506;
      5'd4:  v = 20'd20834;
      5'd5:  v = 20'd10427;
      5'd6:  v = 20'd5215;
      5'd7:  v = 20'd2608;
      5'd8:  v = 20'd1304;
      5'd9:  v = 20'd652;
      5'd10: v = 20'd326;
      5'd11: v = 20'd163;
      5'd12: v = 20'd81;
      5'd13: v = 20'd41;
      5'd14: v = 20'd20;
      5'd15: v = 20'd10;
      5'd16: v = 20'd5;
      5'd17: v = 20'd3;
      5'd18: v = 20'd1;
      5'd19: v = 20'd1;
      default: v = '0;
    endcase
    return v;
  endfunction
endpackage

[sv/pcls_ram.sv]
// Generic single-port-write, single-read synchronous RAM, registered read.
// No dependencies.
module pcls_ram #(
  parameter int Width = 16,
  parameter int Depth = 360
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

[sv/point_cloud_to_laser_scan_core.sv]
// Point-to-scan binning core: one item at a time. A point passes from its
// transfer to the next accept through the accept, 20 CORDIC iterations
// for the bearing, COORD_BITS+1 square-root steps, then a read-modify-write
// on a bin in the range RAM. A dropped point or an ignored kind ends at its
// accept. A read passes through the READ and RESULT states to its registered
// result, and the next accept waits for that result's transfer. A clear sweeps
// the RAM with the default range after its accept. After reset the same
// clearing pass runs before the first item is accepted.
// Depends on pcls_pkg, pcls_ram and assert_macros.svh.
`include "assert_macros.svh"
module point_cloud_to_laser_scan_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  pcls_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output pcls_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  pcls_pkg::cfg_item_t cfg_data
);
  import pcls_pkg::*;

  localparam int BIN_COUNT  = BinCount;
  localparam int COORD_BITS = CoordBits;
  localparam int AW = $clog2(BIN_COUNT);
  localparam int CW = COORD_BITS + GuardBits + 2;     // CORDIC datapath
  localparam int SQW = 2 * COORD_BITS + 1;            // x^2 + z^2
  localparam int SQ_STEPS = (SQW + 1) / 2;
  localparam logic [AW-1:0] LastBin = AW'(BIN_COUNT - 1);

  state_t state, state_next;
  logic signed [15:0] min_h, max_h;
  logic [15:0] dflt;

  logic signed [CW-1:0] cx, cy;
  logic signed [AngBits+1:0] acc;
  logic [4:0] step;
  logic signed [COORD_BITS-1:0] px, pz;
  logic [SQW-1:0] rem;
  logic [SQW-1:0] root;
  logic [AW-1:0] idx, addr;
  logic [8:0] rbin;
  out_item_t out_reg;
  logic out_full;

  // RAM
  logic ram_we;
  logic [AW-1:0] ram_wa, ram_ra;
  logic [15:0] ram_wd, ram_rd;

  pcls_ram #(.Width(16), .Depth(BIN_COUNT)) u_ram (
    .clk(clk), .wr_en(ram_we), .wr_addr(ram_wa), .wr_data(ram_wd),
    .rd_addr(ram_ra), .rd_data(ram_rd)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE) && !out_full;
  assign out_valid = out_full;
  assign out_data  = out_reg;

  // point filter
  logic signed [COORD_BITS:0] hgt;
  logic keep;
  always_comb begin
    hgt = -{in_data.y_mm[COORD_BITS-1], in_data.y_mm[COORD_BITS-1:0]};
    keep = (in_data.x_mm[COORD_BITS-1:0] != '0) && (in_data.y_mm[COORD_BITS-1:0] != '0)
        && (in_data.z_mm[COORD_BITS-1:0] != '0) && !in_data.point_invalid
        && !in_data.z_mm[COORD_BITS-1]
        && (hgt >= (COORD_BITS+1)'(min_h)) && (hgt <= (COORD_BITS+1)'(max_h));
  end

  // square-root step, trial bit two positions lower each step
  logic [SQW-1:0] bitv, trial;
  always_comb begin
    bitv = SQW'(1) << (2 * (SQ_STEPS - 1 - int'(step)));
    trial = root + bitv;
  end

  // bin index from angle
  logic signed [AngBits+1:0] tval;
  logic [AngBits-1:0] tcl;
  logic [AngBits+AW-1:0] prod;
  logic [AW-1:0] idx_calc;
  always_comb begin
    tval = (AngBits+2)'(1 << (AngBits - 1)) - acc;
    if (tval < 0) tcl = '0;
    else if (tval > (AngBits+2)'((1 << AngBits) - 1)) tcl = '1;
    else tcl = tval[AngBits-1:0];
    prod = (AngBits+AW)'(tcl) * (AngBits+AW)'(BIN_COUNT);
    idx_calc = (prod[AngBits+AW-1:AngBits] >= (AW)'(BIN_COUNT)) ? LastBin
             : prod[AngBits+AW-1:AngBits];
  end

  logic [15:0] rsat;
  assign rsat = (root > SQW'(16'hFFFF)) ? 16'hFFFF : root[15:0];

  always_comb begin
    state_next = state;
    ram_we = 1'b0;
    ram_wa = addr;
    ram_wd = dflt;
    ram_ra = idx;
    case (state)
      ST_INIT, ST_CLEAR: begin
        ram_we = 1'b1;
        if (addr == LastBin) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          case (in_data.kind)
            KIND_POINT: if (keep) state_next = ST_CORDIC;
            KIND_READ:  state_next = ST_READ;
            KIND_CLEAR: state_next = ST_CLEAR;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_CORDIC: if (step == 5'(CordicSteps - 1)) state_next = ST_SQRT;
      ST_SQRT: begin
        ram_ra = idx;
        if (step == 5'(SQ_STEPS - 1)) state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        ram_wa = idx;
        ram_wd = rsat;
        ram_we = rsat < ram_rd;
        state_next = ST_IDLE;
      end
      ST_READ: state_next = ST_RESULT;
      ST_RESULT: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      addr <= '0;
      min_h <= 16'sd100;
      max_h <= 16'sd150;
      dflt <= 16'd11000;
      out_full <= 1'b0;
      step <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        case (cfg_data.index)
          REG_MIN_HEIGHT: min_h <= cfg_data.data;
          REG_MAX_HEIGHT: max_h <= cfg_data.data;
          REG_DEFAULT:    dflt <= cfg_data.data;
          default: ;
        endcase
      end
      if (out_full && out_ready) out_full <= 1'b0;
      case (state)
        ST_INIT, ST_CLEAR: addr <= (addr == LastBin) ? '0 : addr + AW'(1);
        ST_IDLE: begin
          step <= '0;
          px <= in_data.x_mm;
          pz <= in_data.z_mm;
          // CORDIC vector (z, x) scaled by the guard
          cx <= CW'(in_data.z_mm) <<< GuardBits;
          cy <= CW'(in_data.x_mm) <<< GuardBits;
          acc <= '0;
          rbin <= (in_data.read_bin >= 9'(BIN_COUNT)) ? 9'(BIN_COUNT - 1)
                                                     : in_data.read_bin;
          idx <= (in_data.read_bin >= 9'(BIN_COUNT)) ? LastBin : AW'(in_data.read_bin);
        end
        ST_CORDIC: begin
          if (!cy[CW-1]) begin
            cx <= cx + (cy >>> step);
            cy <= cy - (cx >>> step);
            acc <= acc + (AngBits+2)'(atan_unit(step));
          end else begin
            cx <= cx - (cy >>> step);
            cy <= cy + (cx >>> step);
            acc <= acc - (AngBits+2)'(atan_unit(step));
          end
          if (step == 5'(CordicSteps - 1)) begin
            step <= '0;
            rem <= SQW'(px * px) + SQW'(pz * pz);
            root <= '0;
          end else step <= step + 5'd1;
        end
        ST_SQRT: begin
          if (step == '0) idx <= idx_calc;
          if (rem >= trial) begin
            rem <= rem - trial;
            root <= (root >> 1) + bitv;
          end else root <= root >> 1;
          step <= step + 5'd1;
        end
        ST_RESULT: begin
          out_reg.bin_number <= rbin;
          out_reg.range_mm <= ram_rd;
          out_full <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  `ASSERT_IMPL(a_accept_idle, in_valid && in_ready, state == ST_IDLE && !out_full)
  `ASSERT_NEXT(a_result_full, state == ST_RESULT, out_full)
  `ASSERT_IMPL(a_no_write_busy, ram_we, state == ST_INIT || state == ST_CLEAR || state == ST_UPDATE)
endmodule
